### rtl/csba_pkg.sv
// ----------------------------------------------------------------------------
// csba_pkg
// shared widths, reset values, codes and controller/datapath link types for
// the contiguous seat block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package csba_pkg;

  // default geometry of the occupancy map
  localparam int ROWS_DEF  = 32;
  localparam int SLOTS_DEF = 16;

  // fixed field widths
  localparam int OPCODE_W    = 1;
  localparam int ZONE_W      = 1;
  localparam int COUNT_W     = 5;
  localparam int REL_ROW_W   = 5;
  localparam int SLOT_IDX_W  = 4;
  localparam int STATUS_W    = 2;
  localparam int COST_W      = 12;
  localparam int ZONE_ROWS_W = 6;
  localparam int PRICE_W     = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = PRICE_W + COUNT_W;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // register reset values
  localparam logic [ZONE_ROWS_W-1:0] ZONE_A_ROWS_RST  = ZONE_ROWS_W'(10);
  localparam logic [PRICE_W-1:0]     PRICE_ZONE_A_RST = PRICE_W'(30);
  localparam logic [PRICE_W-1:0]     PRICE_ZONE_B_RST = PRICE_W'(20);

  typedef enum logic [OPCODE_W-1:0] {
    OP_RESERVE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_A = 1'b0,
    ZONE_B = 1'b1
  } zone_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_GRANTED  = 2'd0,
    STATUS_NO_FIT   = 2'd1,
    STATUS_RELEASED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE_A_ROWS  = 2'd0,
    REG_PRICE_ZONE_A = 2'd1,
    REG_PRICE_ZONE_B = 2'd2
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan;
    logic    write_hit;
    logic    rel_read;
    logic    rel_write;
    logic    out_load;
    status_t out_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/contiguous_seat_block_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_seat_block_allocator
// first-fit contiguous block allocator over a rows-by-slots occupancy map,
// with a two-zone row split, per-zone pricing and block release
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   --------------------  ------------------------------------------
//  in        in_valid / in_ready   opcode, zone, slot_count, release_row,
//                                  release_first, release_last
//  out       out_valid / out_ready status, granted_row, granted_first,
//                                  granted_last, block_cost
//  cfg       cfg_we (no wait)      cfg_index, cfg_data
//
//  reserve: paced by the single read port of the occupancy memory, which
//    the scan walks one row per cycle; a hit on a row of the zone ends the scan
//  release: load, row read, row write, result
//  one beat is worked at a time; in_ready is high only between beats
//  a waiting result sits in the output register, the next input beat can be
//    taken meanwhile and its result is held back until the register frees
//  reset (rst, synchronous) frees every slot at once through per-row valid
//    bits and restores the register defaults; no clearing pass
//
`default_nettype none

module contiguous_seat_block_allocator import csba_pkg::*; #(
  parameter int ROWS          = ROWS_DEF,
  parameter int SLOTS_PER_ROW = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input beat
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OPCODE_W-1:0]   opcode,
  input  logic [ZONE_W-1:0]     zone,
  input  logic [COUNT_W-1:0]    slot_count,
  input  logic [REL_ROW_W-1:0]  release_row,
  input  logic [SLOT_IDX_W-1:0] release_first,
  input  logic [SLOT_IDX_W-1:0] release_last,
  // result beat
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [REL_ROW_W-1:0]  granted_row,
  output logic [SLOT_IDX_W-1:0] granted_first,
  output logic [SLOT_IDX_W-1:0] granted_last,
  output logic [COST_W-1:0]     block_cost,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns in_ready and the result code
  csba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // map memory, search, registers and output register
  csba_dpath #(
    .ROWS          (ROWS),
    .SLOTS_PER_ROW (SLOTS_PER_ROW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .zone          (zone),
    .slot_count    (slot_count),
    .release_row   (release_row),
    .release_first (release_first),
    .release_last  (release_last),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .granted_row   (granted_row),
    .granted_first (granted_first),
    .granted_last  (granted_last),
    .block_cost    (block_cost)
  );

endmodule

`default_nettype wire

### rtl/csba_ctrl.sv
// ----------------------------------------------------------------------------
// csba_ctrl
// sequencer: scan, write-back, release read-modify-write and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module csba_ctrl import csba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] opcode,
  input  sts_t                sts,
  output logic                in_ready,
  output cmd_t                cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_REL_RD,
    S_REL_WR,
    S_FINISH
  } state_t;

  state_t  state;
  status_t res_code;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.out_code = res_code;
    unique case (state)
      S_IDLE:   cmd.load      = in_valid;
      S_SCAN:   cmd.scan      = 1'b1;
      S_WRITE:  cmd.write_hit = 1'b1;
      S_REL_RD: cmd.rel_read  = 1'b1;
      S_REL_WR: cmd.rel_write = 1'b1;
      S_FINISH: cmd.out_load  = !sts.out_busy;
      default:  cmd.load      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_code <= STATUS_NO_FIT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (opcode == OP_RELEASE) ? S_REL_RD : S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.hit) begin
            state <= S_WRITE;
          end else if (sts.scan_done) begin
            res_code <= STATUS_NO_FIT;
            state    <= S_FINISH;
          end
        end
        S_WRITE: begin
          res_code <= STATUS_GRANTED;
          state    <= S_FINISH;
        end
        S_REL_RD: state <= S_REL_WR;
        S_REL_WR: begin
          res_code <= STATUS_RELEASED;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/csba_dpath.sv
// ----------------------------------------------------------------------------
// csba_dpath
// occupancy memory, row scan pipeline, first-fit search, release mask,
// configuration registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module csba_dpath import csba_pkg::*; #(
  parameter int ROWS          = ROWS_DEF,
  parameter int SLOTS_PER_ROW = SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [ZONE_W-1:0]      zone,
  input  logic [COUNT_W-1:0]     slot_count,
  input  logic [REL_ROW_W-1:0]   release_row,
  input  logic [SLOT_IDX_W-1:0]  release_first,
  input  logic [SLOT_IDX_W-1:0]  release_last,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    status,
  output logic [REL_ROW_W-1:0]   granted_row,
  output logic [SLOT_IDX_W-1:0]  granted_first,
  output logic [SLOT_IDX_W-1:0]  granted_last,
  output logic [COST_W-1:0]      block_cost
);

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W  = $clog2(ROWS + 1);
  localparam int SLOT_W = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;

  // configuration registers
  logic [ZONE_ROWS_W-1:0] zone_a_rows;
  logic [PRICE_W-1:0]     price_zone_a;
  logic [PRICE_W-1:0]     price_zone_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_a_rows  <= ZONE_A_ROWS_RST;
      price_zone_a <= PRICE_ZONE_A_RST;
      price_zone_b <= PRICE_ZONE_B_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZONE_A_ROWS:  zone_a_rows  <= cfg_data[ZONE_ROWS_W-1:0];
        REG_PRICE_ZONE_A: price_zone_a <= cfg_data[PRICE_W-1:0];
        REG_PRICE_ZONE_B: price_zone_b <= cfg_data[PRICE_W-1:0];
        default: ;
      endcase
    end
  end

  // zone bounds, boundary saturated at the map height
  logic [CNT_W-1:0] za;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;

  always_comb begin
    if (int'(zone_a_rows) > ROWS) begin
      za = CNT_W'(ROWS);
    end else begin
      za = CNT_W'(zone_a_rows);
    end
    lo = (zone == ZONE_B) ? za : '0;
    hi = (zone == ZONE_B) ? CNT_W'(ROWS) : za;
  end

  // item registers
  logic [COUNT_W-1:0]    count_q;
  logic                  count_ok_q;
  logic [PROD_W-1:0]     cost_q;
  logic [CNT_W-1:0]      hi_q;
  logic [CNT_W-1:0]      rd_row;
  logic [ROW_W-1:0]      rel_idx_q;
  logic                  rel_ok_q;
  logic [SLOT_IDX_W-1:0] rel_first_q;
  logic [SLOT_IDX_W-1:0] rel_last_q;

  logic issue_avail;
  logic scan_issue;
  logic hit;

  assign issue_avail = count_ok_q && (rd_row < hi_q);
  assign scan_issue  = cmd.scan && issue_avail && !hit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_q     <= slot_count;
      count_ok_q  <= (slot_count != '0) && (int'(slot_count) <= SLOTS_PER_ROW);
      cost_q      <= ((zone == ZONE_B) ? price_zone_b : price_zone_a) *
                     PROD_W'(slot_count);
      hi_q        <= hi;
      rd_row      <= lo;
      rel_idx_q   <= ROW_W'(release_row);
      rel_ok_q    <= int'(release_row) < ROWS;
      rel_first_q <= release_first;
      rel_last_q  <= release_last;
    end else if (scan_issue) begin
      rd_row <= rd_row + CNT_W'(1);
    end
  end

  // occupancy memory, rows without a valid bit read as free
  logic [SLOTS_PER_ROW-1:0] mem [ROWS];
  logic [ROWS-1:0]          row_valid;
  logic [ROW_W-1:0]         rd_idx;
  logic                     mem_re;
  logic                     mem_we;
  logic [ROW_W-1:0]         wr_idx;
  logic [SLOTS_PER_ROW-1:0] wdata;
  logic [SLOTS_PER_ROW-1:0] q_data;
  logic                     q_vld;
  logic [ROW_W-1:0]         q_row;
  logic                     q_live;
  logic [SLOTS_PER_ROW-1:0] row_data;

  assign rd_idx = cmd.rel_read ? rel_idx_q : rd_row[ROW_W-1:0];
  assign mem_re = scan_issue || (cmd.rel_read && rel_ok_q);

  always_ff @(posedge clk) begin
    if (mem_re) begin
      q_data <= mem[rd_idx];
      q_vld  <= row_valid[rd_idx];
      q_row  <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      q_live    <= 1'b0;
    end else begin
      q_live <= scan_issue;
      if (mem_we) begin
        row_valid[wr_idx] <= 1'b1;
      end
    end
  end

  assign row_data = q_vld ? q_data : '0;

  // first-fit search on the row just read
  logic [SLOTS_PER_ROW-1:0] win;
  logic [SLOTS_PER_ROW-1:0] free_slots;
  logic [SLOTS_PER_ROW-1:0] fits;
  logic [SLOT_W-1:0]        sel;
  logic [SLOTS_PER_ROW-1:0] grant_mask;

  always_comb begin
    free_slots = ~row_data;
    for (int i = 0; i < SLOTS_PER_ROW; i++) begin
      win[i] = (i < int'(count_q));
    end
    for (int p = 0; p < SLOTS_PER_ROW; p++) begin
      fits[p] = ((p + int'(count_q)) <= SLOTS_PER_ROW) &&
                (((free_slots >> p) & win) == win);
    end
    sel = '0;
    for (int p = SLOTS_PER_ROW - 1; p >= 0; p--) begin
      if (fits[p]) begin
        sel = SLOT_W'(p);
      end
    end
    grant_mask = win << sel;
  end

  assign hit = cmd.scan && q_live && (|fits);

  logic [ROW_W-1:0]         hit_row;
  logic [SLOT_W-1:0]        hit_first;
  logic [SLOT_W-1:0]        hit_last;
  logic [SLOTS_PER_ROW-1:0] hit_wdata;

  always_ff @(posedge clk) begin
    if (hit) begin
      hit_row   <= q_row;
      hit_first <= sel;
      hit_last  <= SLOT_W'(int'(sel) + int'(count_q) - 1);
      hit_wdata <= row_data | grant_mask;
    end
  end

  // release mask, slots beyond the row width fall away
  logic [SLOTS_PER_ROW-1:0] rel_mask;

  always_comb begin
    for (int s = 0; s < SLOTS_PER_ROW; s++) begin
      rel_mask[s] = (s >= int'(rel_first_q)) && (s <= int'(rel_last_q));
    end
  end

  assign mem_we = cmd.write_hit || (cmd.rel_write && rel_ok_q);
  assign wr_idx = cmd.write_hit ? hit_row : rel_idx_q;
  assign wdata  = cmd.write_hit ? hit_wdata : (row_data & ~rel_mask);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_code;
      if (cmd.out_code == STATUS_GRANTED) begin
        granted_row   <= REL_ROW_W'(hit_row);
        granted_first <= SLOT_IDX_W'(hit_first);
        granted_last  <= SLOT_IDX_W'(hit_last);
        block_cost    <= (cost_q > PROD_W'(COST_MAX)) ? COST_MAX : COST_W'(cost_q);
      end else begin
        granted_row   <= '0;
        granted_first <= '0;
        granted_last  <= '0;
        block_cost    <= '0;
      end
    end
  end

  assign sts.hit       = hit;
  assign sts.scan_done = !q_live && !issue_avail;
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

`default_nettype wire

### rtl/csba_checker.sv
// ----------------------------------------------------------------------------
// csba_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module csba_checker import csba_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [STATUS_W-1:0]   status,
  input logic [REL_ROW_W-1:0]  granted_row,
  input logic [SLOT_IDX_W-1:0] granted_first,
  input logic [SLOT_IDX_W-1:0] granted_last,
  input logic [COST_W-1:0]     block_cost
);

  // after reset nothing is pending and the input side is open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("allocator not idle after reset");

  // one beat at a time: an accepted beat closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a beat is in work");

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
      $stable(granted_row) && $stable(block_cost)))
    else $error("stalled result changed");

  // anything but a grant reports zero position and cost
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_GRANTED)) |->
      (granted_row == '0 && granted_first == '0 &&
       granted_last == '0 && block_cost == '0))
    else $error("non-grant result carries block fields");

endmodule

bind contiguous_seat_block_allocator csba_checker u_csba_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .granted_row   (granted_row),
  .granted_first (granted_first),
  .granted_last  (granted_last),
  .block_cost    (block_cost)
);

`default_nettype wire

### tb/sv/seat_map_checker.sv
// ----------------------------------------------------------------------------
// seat_map_checker
// watches the request, result and register ports of the seat block allocator,
// keeps its own occupancy map and registers, predicts one result per request
// beat and compares every result beat field by field against the oldest one
// ----------------------------------------------------------------------------

module seat_map_checker import csba_pkg::*; #(
  parameter int ROWS  = ROWS_DEF,
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OPCODE_W-1:0]   opcode,
  input  logic [ZONE_W-1:0]     zone,
  input  logic [COUNT_W-1:0]    slot_count,
  input  logic [REL_ROW_W-1:0]  release_row,
  input  logic [SLOT_IDX_W-1:0] release_first,
  input  logic [SLOT_IDX_W-1:0] release_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [STATUS_W-1:0]   status,
  input  logic [REL_ROW_W-1:0]  granted_row,
  input  logic [SLOT_IDX_W-1:0] granted_first,
  input  logic [SLOT_IDX_W-1:0] granted_last,
  input  logic [COST_W-1:0]     block_cost,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                status;
    logic [REL_ROW_W-1:0]  row;
    logic [SLOT_IDX_W-1:0] first;
    logic [SLOT_IDX_W-1:0] last;
    logic [COST_W-1:0]     cost;
  } alloc_result_t;

  logic [SLOTS-1:0]       seat_map [ROWS];
  logic [ZONE_ROWS_W-1:0] zone_a_rows_q;
  logic [PRICE_W-1:0]     price_a_q;
  logic [PRICE_W-1:0]     price_b_q;
  alloc_result_t          awaited_allocs [$];
  int                     mismatches;

  // first-fit search over the rows of one zone, or a plain row release
  function automatic alloc_result_t predict_seat_op(opcode_t op, zone_t zn,
      logic [COUNT_W-1:0] cnt, logic [REL_ROW_W-1:0] rrow,
      logic [SLOT_IDX_W-1:0] rfirst, logic [SLOT_IDX_W-1:0] rlast);
    alloc_result_t     res;
    int                lo;
    int                hi;
    int                za;
    int                run;
    int unsigned       cost;
    logic [PRICE_W-1:0] price;
    res = '0;
    if (op == OP_RELEASE) begin
      res.status = STATUS_RELEASED;
      if (rrow < ROWS) begin
        for (int s = rfirst; s <= rlast && s < SLOTS; s++) seat_map[rrow][s] = 1'b0;
      end
      return res;
    end
    res.status = STATUS_NO_FIT;
    if (cnt == 0 || cnt > SLOTS) return res;
    za = (zone_a_rows_q > ROWS) ? ROWS : zone_a_rows_q;
    if (zn == ZONE_A) begin
      lo = 0;
      hi = za;
      price = price_a_q;
    end else begin
      lo = za;
      hi = ROWS;
      price = price_b_q;
    end
    for (int r = lo; r < hi; r++) begin
      run = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (!seat_map[r][s]) run++;
        else run = 0;
        if (run == cnt) begin
          for (int k = s + 1 - run; k <= s; k++) seat_map[r][k] = 1'b1;
          cost = price * cnt;
          if (cost > COST_MAX) cost = COST_MAX;
          res.status = STATUS_GRANTED;
          res.row    = REL_ROW_W'(r);
          res.first  = SLOT_IDX_W'(s + 1 - run);
          res.last   = SLOT_IDX_W'(s);
          res.cost   = COST_W'(cost);
          return res;
        end
      end
    end
    return res;
  endfunction

  task automatic check_result_beat();
    alloc_result_t want;
    if (awaited_allocs.size() == 0) begin
      $error("result beat with no request waiting: status %0d", status);
      mismatches++;
      return;
    end
    want = awaited_allocs.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, status);
      mismatches++;
    end
    if (granted_row !== want.row) begin
      $error("granted_row: expected %0d, actual %0d", want.row, granted_row);
      mismatches++;
    end
    if (granted_first !== want.first) begin
      $error("granted_first: expected %0d, actual %0d", want.first, granted_first);
      mismatches++;
    end
    if (granted_last !== want.last) begin
      $error("granted_last: expected %0d, actual %0d", want.last, granted_last);
      mismatches++;
    end
    if (block_cost !== want.cost) begin
      $error("block_cost: expected %0d, actual %0d", want.cost, block_cost);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      foreach (seat_map[r]) seat_map[r] = '0;
      zone_a_rows_q = ZONE_A_ROWS_RST;
      price_a_q     = PRICE_ZONE_A_RST;
      price_b_q     = PRICE_ZONE_B_RST;
      awaited_allocs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ZONE_A_ROWS:  zone_a_rows_q = cfg_data[ZONE_ROWS_W-1:0];
          REG_PRICE_ZONE_A: price_a_q     = cfg_data[PRICE_W-1:0];
          REG_PRICE_ZONE_B: price_b_q     = cfg_data[PRICE_W-1:0];
          default: ;
        endcase
      end
      // results first: a result beat on this edge belongs to an older request
      if (out_valid && out_ready) check_result_beat();
      if (in_valid && in_ready) begin
        awaited_allocs.push_back(predict_seat_op(opcode_t'(opcode), zone_t'(zone),
            slot_count, release_row, release_first, release_last));
      end
    end
    fail_count  <= mismatches;
    results_due <= awaited_allocs.size();
  end

endmodule

### tb/sv/tb_contiguous_seat_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_contiguous_seat_block_allocator
// drives reserve and release beats into the seat block allocator under three
// idling mixes and a series of zone and price settings; a checker beside the
// block predicts and compares every result and hands back a failure count
// ----------------------------------------------------------------------------

module tb_contiguous_seat_block_allocator import csba_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SEGS    = 8;
  localparam int SEG_ITEMS   = 200;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_TAIL  = 40;    // a full-zone scan plus margin
  localparam int STALL_LIMIT = 4000;  // cycles with no beat at all

  typedef struct packed {
    opcode_t                op;
    zone_t                  zn;
    logic [COUNT_W-1:0]    cnt;
    logic [REL_ROW_W-1:0]  row;
    logic [SLOT_IDX_W-1:0] first;
    logic [SLOT_IDX_W-1:0] last;
  } seat_req_t;

  typedef struct packed {
    logic [REL_ROW_W-1:0]  row;
    logic [SLOT_IDX_W-1:0] first;
    logic [SLOT_IDX_W-1:0] last;
  } seat_block_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [ZONE_W-1:0]     zone;
  logic [COUNT_W-1:0]    slot_count;
  logic [REL_ROW_W-1:0]  release_row;
  logic [SLOT_IDX_W-1:0] release_first;
  logic [SLOT_IDX_W-1:0] release_last;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATUS_W-1:0]   status;
  logic [REL_ROW_W-1:0]  granted_row;
  logic [SLOT_IDX_W-1:0] granted_first;
  logic [SLOT_IDX_W-1:0] granted_last;
  logic [COST_W-1:0]     block_cost;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          fail_count;
  int          results_due;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;
  int          idle_cycles = 0;
  seat_block_t held_blocks [$];

  // per-segment register settings; extremes first, the last two drawn at random
  // 202 on the zone boundary checks that only the low six bits count
  int seg_rows  [NUM_SEGS] = '{0, 63, 32, 1, 31, 202, 0, 0};
  int seg_price_a [NUM_SEGS] = '{255, 0, 255, 17, 99, 30, 0, 0};
  int seg_price_b [NUM_SEGS] = '{255, 255, 0, 200, 1, 20, 0, 0};
  int seg_reserve_pct [NUM_SEGS] = '{75, 60, 80, 55, 70, 50, 65, 60};

  contiguous_seat_block_allocator u_top (.*);

  seat_map_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // granted blocks are remembered so later releases hit real allocations;
  // sampled at the falling edge, where the result port is stable
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready && status == STATUS_GRANTED)
      held_blocks.push_back({granted_row, granted_first, granted_last});
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: ends the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic seat_req_t mk_reserve(zone_t zn, int cnt);
    seat_req_t req;
    req = '0;
    req.op  = OP_RESERVE;
    req.zn  = zn;
    req.cnt = COUNT_W'(cnt);
    return req;
  endfunction

  function automatic seat_req_t mk_release(int row, int first, int last);
    seat_req_t req;
    req = '0;
    req.op    = OP_RELEASE;
    req.row   = REL_ROW_W'(row);
    req.first = SLOT_IDX_W'(first);
    req.last  = SLOT_IDX_W'(last);
    return req;
  endfunction

  // mostly reserves of small counts and releases of blocks actually held;
  // the fields an operation ignores carry random noise
  function automatic seat_req_t random_request(int reserve_pct);
    seat_req_t   req;
    seat_block_t blk;
    int          pick;
    int          idx;
    req.zn    = zone_t'($urandom_range(0, 1));
    req.cnt   = COUNT_W'($urandom_range(0, 31));
    req.row   = REL_ROW_W'($urandom_range(0, 31));
    req.first = SLOT_IDX_W'($urandom_range(0, 15));
    req.last  = SLOT_IDX_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < reserve_pct) begin
      req.op = OP_RESERVE;
      pick = $urandom_range(0, 99);
      if (pick < 6) req.cnt = '0;
      else if (pick < 12) req.cnt = COUNT_W'($urandom_range(17, 31));
      else if (pick < 50) req.cnt = COUNT_W'($urandom_range(1, 4));
      else req.cnt = COUNT_W'($urandom_range(1, 16));
    end else begin
      req.op = OP_RELEASE;
      pick = $urandom_range(0, 99);
      if (pick < 70 && held_blocks.size() != 0) begin
        idx = $urandom_range(0, held_blocks.size() - 1);
        blk = held_blocks[idx];
        held_blocks.delete(idx);
        req.row   = blk.row;
        req.first = blk.first;
        req.last  = blk.last;
      end else if (pick < 85) begin
        // clear a whole row
        req.first = '0;
        req.last  = '1;
      end
    end
    return req;
  endfunction

  // present one beat and hold it until the block takes it
  task automatic offer_beat(seat_req_t req);
    opcode        <= req.op;
    zone          <= req.zn;
    slot_count    <= req.cnt;
    release_row   <= req.row;
    release_first <= req.first;
    release_last  <= req.last;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    while ($urandom_range(0, 99) < send_idle_pct) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result; the first edge lets
  // the checker count the last request
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_regs(int rows, int price_a, int price_b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ZONE_A_ROWS;
    cfg_data  <= CFG_DATA_W'(rows);
    @(posedge clk);
    cfg_index <= REG_PRICE_ZONE_A;
    cfg_data  <= CFG_DATA_W'(price_a);
    @(posedge clk);
    cfg_index <= REG_PRICE_ZONE_B;
    cfg_data  <= CFG_DATA_W'(price_b);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    seat_req_t directed_reqs [$];
    int        rows;
    int        price_a;
    int        price_b;
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_RESERVE;
    zone          = ZONE_A;
    slot_count    = '0;
    release_row   = '0;
    release_first = '0;
    release_last  = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_ZONE_A_ROWS;
    cfg_data      = '0;
    hold_req      = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 66;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset register values
    directed_reqs.push_back(mk_reserve(ZONE_A, 0));    // zero count
    directed_reqs.push_back(mk_reserve(ZONE_A, 17));   // just above row width
    directed_reqs.push_back(mk_reserve(ZONE_B, 31));   // largest count
    directed_reqs.push_back(mk_reserve(ZONE_A, 16));   // full row
    directed_reqs.push_back(mk_reserve(ZONE_A, 1));
    directed_reqs.push_back(mk_reserve(ZONE_A, 15));   // rest of that row
    directed_reqs.push_back(mk_reserve(ZONE_B, 16));   // first row of zone B
    directed_reqs.push_back(mk_reserve(ZONE_B, 3));
    directed_reqs.push_back(mk_release(1, 5, 7));      // hole in a full row
    directed_reqs.push_back(mk_reserve(ZONE_A, 3));    // first fit into that hole
    directed_reqs.push_back(mk_reserve(ZONE_A, 4));
    directed_reqs.push_back(mk_release(31, 0, 15));    // release of free slots
    directed_reqs.push_back(mk_release(0, 9, 3));      // first above last
    directed_reqs.push_back(mk_release(0, 15, 15));    // last slot alone
    directed_reqs.push_back(mk_reserve(ZONE_A, 1));    // lands on slot 15
    directed_reqs.push_back(mk_release(0, 0, 15));
    directed_reqs.push_back(mk_reserve(ZONE_A, 2));
    directed_reqs.push_back(mk_release(31, 15, 15));
    foreach (directed_reqs[i]) begin
      sender_gap();
      offer_beat(directed_reqs[i]);
    end

    // random segments, each with its own register setting and idling mix
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain_results();
      rows    = seg_rows[seg];
      price_a = seg_price_a[seg];
      price_b = seg_price_b[seg];
      if (seg >= 6) begin
        rows    = $urandom_range(0, 40);
        price_a = $urandom_range(0, 255);
        price_b = $urandom_range(0, 255);
      end
      write_regs(rows, price_a, price_b);
      // sender light / receiver heavy, then swapped, then no idling
      send_idle_pct <= (seg < 3) ? 19 : (seg < 6) ? 66 : 0;
      recv_idle_pct <= (seg < 3) ? 66 : (seg < 6) ? 19 : 0;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // receiver stops for a long stretch while requests keep coming;
        // the request stays up while the beat is offered, so the sink samples it
        if (seg % 3 == 0 && n == SEG_ITEMS / 2) hold_req <= 1'b1;
        sender_gap();
        offer_beat(random_request(seg_reserve_pct[seg]));
        hold_req <= 1'b0;
        // sender waits for all results a quarter of the way into a segment too
        if (n == SEG_ITEMS / 4) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/csba_pkg.sv
rtl/csba_ctrl.sv
rtl/csba_dpath.sv
rtl/contiguous_seat_block_allocator.sv
rtl/csba_checker.sv
tb/sv/seat_map_checker.sv
tb/sv/tb_contiguous_seat_block_allocator.sv
